[design/assert_macros.svh]
// Assertion helpers for the priority queue checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, quiet while reset is asserted.
`define SPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same, for a property that must hold in the cycle after a trigger.
`define SPQ_ASSERT_NEXT(label, trig, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (prop)) \
    else $error(msg);

`endif

[design/spq_pkg.sv]
package spq_pkg;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef struct packed {
    logic signed [31:0] key;
    logic [15:0]        id;
  } entry_t;

  // per-cell control from the top level
  typedef struct packed {
    logic ins;       // insert accepted, queue not full
    logic rem;       // remove accepted, queue not empty
    logic occupied;  // cell holds a valid entry
    logic at_end;    // cell is the first free slot
  } cell_ctrl_t;

endpackage

[design/sorted_priority_queue_core.sv]
// Sorted min-priority queue of (vertex id, key) pairs, built as a row of
// CAPACITY cells kept in ascending key order (cell 0 is the head). Every cell
// compares its key against the incoming one in parallel; on an insert the
// cells from the insertion point on shift one place toward the tail and the
// new pair drops into the gap, after all entries with an equal or smaller key,
// so equal keys leave in arrival order. On a remove each cell but the last
// takes its right neighbor's entry and the old head is reported. Keys are
// signed Q16.16. One transfer in yields one out, from the output register in
// the next cycle. One item per cycle is taken unless the result stream stalls;
// throughput is set only by the output register, refilled the cycle it drains.
// Remove on an empty queue reports removed_valid = 0 with zero id and key;
// insert into a full queue is dropped and flagged with insert_dropped.
module sorted_priority_queue_core #(
  parameter int CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // [15:0] vertex_id, [47:16] key
  input  logic [0:0]  s_axis_tuser,   // [0] operation
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [15:0] removed_id, [47:16] removed_key,
                                      // [48] not_empty, [55:49] entry_count
  output logic [1:0]  m_axis_tuser    // [0] removed_valid, [1] insert_dropped
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0] count_q, count_d;
  logic             accept, is_insert, full, empty, do_ins, do_rem, dropped;
  entry_t           new_entry;

  entry_t     cell_entry [CAPACITY];
  logic       cell_take  [CAPACITY];
  cell_ctrl_t cell_ctrl  [CAPACITY];

  // result register
  logic        out_valid_q;
  logic        rvalid_q, dropped_q;
  entry_t      rentry_q;
  logic [CNT_W-1:0] rcount_q;
  logic [CNT_W+6:0] rcount_ext;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_insert     = (op_e'(s_axis_tuser[0]) == OP_INSERT);
  assign new_entry.id  = s_axis_tdata[15:0];
  assign new_entry.key = s_axis_tdata[47:16];

  assign full    = (count_q == CNT_W'(CAPACITY));
  assign empty   = (count_q == '0);
  assign do_ins  = accept && is_insert && !full;
  assign do_rem  = accept && !is_insert && !empty;
  assign dropped = accept && is_insert && full;

  always_comb begin
    count_d = count_q;
    if (do_ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_rem) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // the cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign cell_ctrl[i].ins      = do_ins;
    assign cell_ctrl[i].rem      = do_rem;
    assign cell_ctrl[i].occupied = (CNT_W'(i) < count_q);
    assign cell_ctrl[i].at_end   = (CNT_W'(i) == count_q);

    spq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (cell_ctrl[i]),
      .new_i       (new_entry),
      .left_i      ((i == 0) ? new_entry : cell_entry[(i == 0) ? 0 : i - 1]),
      .take_left_i ((i == 0) ? 1'b0 : cell_take[(i == 0) ? 0 : i - 1]),
      .right_i     (cell_entry[(i == CAPACITY - 1) ? i : i + 1]),
      .take_o      (cell_take[i]),
      .entry_o     (cell_entry[i])
    );
  end

  // output stage: refilled whenever an item is accepted
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rvalid_q  <= do_rem;
      dropped_q <= dropped;
      rentry_q  <= do_rem ? cell_entry[0] : '0;
      rcount_q  <= count_d;
    end
  end

  // entry_count carries the low 7 bits of the occupancy
  assign rcount_ext = {7'b0, rcount_q};

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {rcount_ext[6:0], (rcount_q != '0), rentry_q.key, rentry_q.id};
  assign m_axis_tuser  = {dropped_q, rvalid_q};

endmodule

[design/spq_cell.sv]
module spq_cell (
  input  logic               clk_i,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  spq_pkg::entry_t    new_i,
  input  spq_pkg::entry_t    left_i,
  input  logic               take_left_i,
  input  spq_pkg::entry_t    right_i,
  output logic               take_o,
  output spq_pkg::entry_t    entry_o
);
  import spq_pkg::*;

  entry_t entry_q, entry_d;
  logic   gt;

  // stored key strictly greater than the new one: new entry goes at or before us
  assign gt     = ctrl_i.occupied && (entry_q.key > new_i.key);
  assign take_o = gt || ctrl_i.at_end;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins && take_o) begin
      entry_d = take_left_i ? left_i : new_i;
    end else if (ctrl_i.rem) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

[design/spq_checker.sv]
`include "assert_macros.svh"

module spq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // a stalled result holds
  `SPQ_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

  // every input transfer is answered by a result in the next cycle
  `SPQ_ASSERT_NEXT(a_in_result, s_axis_tvalid && s_axis_tready, m_axis_tvalid, "input transfer without a result")

  // a result is either a removal or a dropped insert, never both
  `SPQ_ASSERT(a_flags_excl, m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]), "removed and dropped together")

  // nonzero count means the queue is not empty
  `SPQ_ASSERT(a_count_nonempty, (m_axis_tvalid && (m_axis_tdata[55:49] != 7'd0)) |-> m_axis_tdata[48], "count without not_empty")

  // a dropped insert means the queue was full, so not empty
  `SPQ_ASSERT(a_drop_full, (m_axis_tvalid && m_axis_tuser[1]) |-> m_axis_tdata[48], "dropped insert on non-full queue")

endmodule

bind sorted_priority_queue_core spq_checker u_spq_checker (.*);
